[rtl/core/cc20_pkg.sv]
// ----------------------------------------------------------------------------
// cc20_pkg : shared types and constants of the ChaCha20 stream block
// Holds the round count, the sigma words, the item and configuration
// structs, the generator control structs and the quarter-round function.
// ----------------------------------------------------------------------------
package cc20_pkg;

    // Rounds per keystream block
    localparam int DOUBLE_ROUNDS = 10;
    localparam int NUM_ROUNDS    = 2 * DOUBLE_ROUNDS;
    localparam int ROUND_W       = $clog2(NUM_ROUNDS);

    // "expand 32-byte k"
    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    localparam int BLOCK_W  = 512;
    localparam int POS_W    = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_0_7   = 3'd0,
        CFG_KEY_8_15  = 3'd1,
        CFG_KEY_16_23 = 3'd2,
        CFG_KEY_24_31 = 3'd3,
        CFG_NONCE_0_7 = 3'd4,
        CFG_NONCE_8_11 = 3'd5,
        CFG_INIT_CTR  = 3'd6
    } t_cfg_idx;

    // Key, nonce and initial counter as written
    typedef struct packed {
        logic [63:0] key_0_7;
        logic [63:0] key_8_15;
        logic [63:0] key_16_23;
        logic [63:0] key_24_31;
        logic [63:0] nonce_0_7;
        logic [31:0] nonce_8_11;
        logic [31:0] init_ctr;
    } t_cfg;

    // One message byte with its flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       zero_input;
        logic       last_byte;
    } t_item;

    // Block generator request and status
    typedef struct packed {
        logic        start;
        logic [31:0] counter;
    } t_gen_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_gen_rsp;

    typedef enum logic [1:0] {
        GEN_IDLE,
        GEN_ROUND,
        GEN_ADD
    } t_gen_state;

    // Quarter round on four words, returned as {a, b, c, d}
    function automatic logic [127:0] qround(input logic [31:0] a_in,
                                            input logic [31:0] b_in,
                                            input logic [31:0] c_in,
                                            input logic [31:0] d_in);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        a = a_in;
        b = b_in;
        c = c_in;
        d = d_in;
        a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
        c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
        a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
        c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
        return {a, b, c, d};
    endfunction

endpackage

[rtl/core/chacha20_stream_xor.sv]
// ----------------------------------------------------------------------------
// chacha20_stream_xor : ChaCha20 stream XOR, one byte per beat
// Top level: configuration registers, input queue and back end.
// ----------------------------------------------------------------------------
// Usage:
//   Write key, nonce and initial block counter through the write port
//   (index 0..6, little-endian packing) while the block is idle.
//   Input channel carries one message byte per beat with zero_input and
//   last_byte flags; output channel returns the XORed byte and last flag.
//   An input beat passes through the input queue and then the output register.
//   The first byte of each 64-byte block waits for the block generator:
//   a start request, the rounds and the feed-forward add.
//   Throughput: one byte per cycle within a block while the receiver keeps up;
//   the single round unit starts the next block only once the current one is used up.
//   A last byte ends the message; the next byte restarts at the initial
//   counter. The counter wraps modulo 2^32.
//   Reset clears the configuration and control registers and empties the queue and output.
//   When the receiver stalls, the result is held in the output register,
//   the back end stops, and the two-entry input queue fills before the
//   input ready drops.
// ----------------------------------------------------------------------------
module chacha20_stream_xor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_zero_input,
    input  logic                                i_last_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [7:0]                          o_result_byte,
    output logic                                o_result_last
);

    cc20_pkg::t_cfg  r_cfg;
    cc20_pkg::t_item in_item;
    cc20_pkg::t_item head;
    logic            head_valid;
    logic            pop;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                cc20_pkg::CFG_KEY_0_7:    r_cfg.key_0_7    <= i_cfg_wdata;
                cc20_pkg::CFG_KEY_8_15:   r_cfg.key_8_15   <= i_cfg_wdata;
                cc20_pkg::CFG_KEY_16_23:  r_cfg.key_16_23  <= i_cfg_wdata;
                cc20_pkg::CFG_KEY_24_31:  r_cfg.key_24_31  <= i_cfg_wdata;
                cc20_pkg::CFG_NONCE_0_7:  r_cfg.nonce_0_7  <= i_cfg_wdata;
                cc20_pkg::CFG_NONCE_8_11: r_cfg.nonce_8_11 <= i_cfg_wdata[31:0];
                cc20_pkg::CFG_INIT_CTR:   r_cfg.init_ctr   <= i_cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    assign in_item.data_byte  = i_data_byte;
    assign in_item.zero_input = i_zero_input;
    assign in_item.last_byte  = i_last_byte;

    cc20_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_item       (in_item),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    cc20_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_byte (o_result_byte),
        .o_result_last (o_result_last)
    );

endmodule

[rtl/core/cc20_front.sv]
// ----------------------------------------------------------------------------
// cc20_front : input queue
// Accepts message bytes on the input channel and holds up to two of them
// for the back end, so the input side waits on the output side only when both are full.
// ----------------------------------------------------------------------------
module cc20_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cc20_pkg::t_item i_item,
    output logic           o_head_valid,
    output cc20_pkg::t_item o_head,
    input  logic           i_pop
);

    cc20_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    logic push;
    logic pop;

    assign o_in_ready   = (r_count != 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rd_ptr];

    assign push = i_in_valid && o_in_ready;
    assign pop  = i_pop && o_head_valid;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Store the accepted beat
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[rtl/core/cc20_rounds.sv]
// ----------------------------------------------------------------------------
// cc20_rounds : keystream block generator
// Builds the initial state from key, nonce and counter, runs one round per
// cycle on sixteen working words, then adds the initial state back in.
// ----------------------------------------------------------------------------
module cc20_rounds (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cc20_pkg::t_cfg                  i_cfg,
    input  cc20_pkg::t_gen_req              i_req,
    output cc20_pkg::t_gen_rsp              o_rsp,
    output logic [cc20_pkg::BLOCK_W-1:0]    o_block
);

    cc20_pkg::t_gen_state          r_state;
    cc20_pkg::t_gen_state          n_state;
    logic [cc20_pkg::ROUND_W-1:0]  r_round;
    logic [31:0]                   r_w [16];

    logic [31:0]  init_w [16];
    logic [31:0]  rnd_w  [16];
    logic [127:0] q0;
    logic [127:0] q1;
    logic [127:0] q2;
    logic [127:0] q3;
    logic         last_round;

    // Initial state words; counter comes from the request
    always_comb begin
        init_w[0]  = cc20_pkg::SIGMA0;
        init_w[1]  = cc20_pkg::SIGMA1;
        init_w[2]  = cc20_pkg::SIGMA2;
        init_w[3]  = cc20_pkg::SIGMA3;
        init_w[4]  = i_cfg.key_0_7[31:0];
        init_w[5]  = i_cfg.key_0_7[63:32];
        init_w[6]  = i_cfg.key_8_15[31:0];
        init_w[7]  = i_cfg.key_8_15[63:32];
        init_w[8]  = i_cfg.key_16_23[31:0];
        init_w[9]  = i_cfg.key_16_23[63:32];
        init_w[10] = i_cfg.key_24_31[31:0];
        init_w[11] = i_cfg.key_24_31[63:32];
        init_w[12] = i_req.counter;
        init_w[13] = i_cfg.nonce_0_7[31:0];
        init_w[14] = i_cfg.nonce_0_7[63:32];
        init_w[15] = i_cfg.nonce_8_11;
    end

    // One round: columns on even rounds, diagonals on odd rounds
    always_comb begin
        if (!r_round[0]) begin
            q0 = cc20_pkg::qround(r_w[0], r_w[4], r_w[8],  r_w[12]);
            q1 = cc20_pkg::qround(r_w[1], r_w[5], r_w[9],  r_w[13]);
            q2 = cc20_pkg::qround(r_w[2], r_w[6], r_w[10], r_w[14]);
            q3 = cc20_pkg::qround(r_w[3], r_w[7], r_w[11], r_w[15]);
            {rnd_w[0], rnd_w[4], rnd_w[8],  rnd_w[12]} = q0;
            {rnd_w[1], rnd_w[5], rnd_w[9],  rnd_w[13]} = q1;
            {rnd_w[2], rnd_w[6], rnd_w[10], rnd_w[14]} = q2;
            {rnd_w[3], rnd_w[7], rnd_w[11], rnd_w[15]} = q3;
        end else begin
            q0 = cc20_pkg::qround(r_w[0], r_w[5], r_w[10], r_w[15]);
            q1 = cc20_pkg::qround(r_w[1], r_w[6], r_w[11], r_w[12]);
            q2 = cc20_pkg::qround(r_w[2], r_w[7], r_w[8],  r_w[13]);
            q3 = cc20_pkg::qround(r_w[3], r_w[4], r_w[9],  r_w[14]);
            {rnd_w[0], rnd_w[5], rnd_w[10], rnd_w[15]} = q0;
            {rnd_w[1], rnd_w[6], rnd_w[11], rnd_w[12]} = q1;
            {rnd_w[2], rnd_w[7], rnd_w[8],  rnd_w[13]} = q2;
            {rnd_w[3], rnd_w[4], rnd_w[9],  rnd_w[14]} = q3;
        end
    end

    // Feed-forward add, word 0 in the low bits, little-endian bytes
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            o_block[32*i +: 32] = r_w[i] + init_w[i];
        end
    end

    assign last_round = (r_round == cc20_pkg::ROUND_W'(cc20_pkg::NUM_ROUNDS - 1));

    // Hold the sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cc20_pkg::GEN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and status
    always_comb begin
        n_state    = r_state;
        o_rsp.busy = 1'b0;
        o_rsp.done = 1'b0;
        case (r_state)
            cc20_pkg::GEN_IDLE: begin
                if (i_req.start) begin
                    n_state = cc20_pkg::GEN_ROUND;
                end
            end
            cc20_pkg::GEN_ROUND: begin
                o_rsp.busy = 1'b1;
                if (last_round) begin
                    n_state = cc20_pkg::GEN_ADD;
                end
            end
            cc20_pkg::GEN_ADD: begin
                o_rsp.busy = 1'b1;
                o_rsp.done = 1'b1;
                n_state    = cc20_pkg::GEN_IDLE;
            end
            default: begin
                n_state = cc20_pkg::GEN_IDLE;
            end
        endcase
    end

    // Round counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= '0;
        end else if (r_state == cc20_pkg::GEN_ROUND) begin
            r_round <= last_round ? '0 : r_round + 1'b1;
        end else begin
            r_round <= '0;
        end
    end

    // Load or advance the working words
    always_ff @(posedge i_clk) begin
        if (r_state == cc20_pkg::GEN_IDLE && i_req.start) begin
            r_w <= init_w;
        end else if (r_state == cc20_pkg::GEN_ROUND) begin
            r_w <= rnd_w;
        end
    end

endmodule

[rtl/core/cc20_back.sv]
// ----------------------------------------------------------------------------
// cc20_back : keystream sequencing and output stage
// Tracks message, block counter and byte position, asks the generator for
// a block on demand, XORs each byte and holds the result for the receiver.
// ----------------------------------------------------------------------------
module cc20_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cc20_pkg::t_cfg  i_cfg,
    input  logic            i_head_valid,
    input  cc20_pkg::t_item i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_result_byte,
    output logic            o_result_last
);

    logic                          r_open;
    logic                          r_ks_valid;
    logic [cc20_pkg::POS_W-1:0]    r_pos;
    logic [31:0]                   r_counter;
    logic [cc20_pkg::BLOCK_W-1:0]  r_ks;
    logic                          r_out_valid;
    logic [7:0]                    r_out_byte;
    logic                          r_out_last;

    cc20_pkg::t_gen_req            gen_req;
    cc20_pkg::t_gen_rsp            gen_rsp;
    logic [cc20_pkg::BLOCK_W-1:0]  gen_block;
    logic                          out_free;
    logic [7:0]                    in_byte;

    // Request a block when a byte waits and no keystream is on hand
    assign gen_req.start   = i_head_valid && !r_ks_valid && !gen_rsp.busy;
    assign gen_req.counter = r_open ? r_counter : i_cfg.init_ctr;

    cc20_rounds u_rounds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_req   (gen_req),
        .o_rsp   (gen_rsp),
        .o_block (gen_block)
    );

    assign out_free = !r_out_valid || i_out_ready;
    assign o_pop    = i_head_valid && r_ks_valid && out_free;
    assign in_byte  = i_head.zero_input ? 8'h00 : i_head.data_byte;

    // Message and block bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_ks_valid <= 1'b0;
            r_pos      <= '0;
            r_counter  <= '0;
        end else begin
            if (gen_req.start) begin
                r_open    <= 1'b1;
                r_counter <= gen_req.counter;
            end
            if (gen_rsp.done) begin
                r_ks_valid <= 1'b1;
            end
            if (o_pop) begin
                r_pos <= r_pos + 1'b1;
                if (r_pos == '1) begin
                    r_ks_valid <= 1'b0;
                    r_counter  <= r_counter + 32'd1;
                end
                if (i_head.last_byte) begin
                    r_open     <= 1'b0;
                    r_ks_valid <= 1'b0;
                    r_pos      <= '0;
                end
            end
        end
    end

    // Load the block, then shift one byte out per beat
    always_ff @(posedge i_clk) begin
        if (gen_rsp.done) begin
            r_ks <= gen_block;
        end else if (o_pop) begin
            r_ks <= {8'h00, r_ks[cc20_pkg::BLOCK_W-1:8]};
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_byte <= in_byte ^ r_ks[7:0];
            r_out_last <= i_head.last_byte;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_byte = r_out_byte;
    assign o_result_last = r_out_last;

endmodule

[rtl/core/cc20_checker.sv]
// ----------------------------------------------------------------------------
// cc20_checker : port-level checks for the ChaCha20 stream block
// Watches the top-level ports and flags handshake and reset slips.
// ----------------------------------------------------------------------------
module cc20_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_result_byte,
    input logic       o_result_last
);

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // Keep a stalled payload stable
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_result_byte) && $stable(o_result_last))
        else $error("output payload changed while stalled");

    // Empty output after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Empty queue after reset
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

endmodule

bind chacha20_stream_xor cc20_checker u_cc20_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_result_byte (o_result_byte),
    .o_result_last (o_result_last)
);
